FILE: hdl/fcg_pkg.sv
// ----------------------------------------------------------------------------
// fcg_pkg
// Shared types and constants of the four-corner gradient pixel generator.
// ----------------------------------------------------------------------------
package fcg_pkg;

   // field widths
   localparam int COORD_W   = 12;
   localparam int DIM_W     = 13;
   localparam int RGB_W     = 24;
   localparam int CH_W      = 8;
   localparam int NUM_CH    = 3;
   localparam int BLEND_W   = 21;
   localparam int NUM_W     = 32;
   localparam int DEN_W     = 26;
   localparam int DEF_MAX_DIM = 4096;

   // configuration port
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;

   // register indexes
   localparam logic [2:0] REG_WIDTH  = 3'd0;
   localparam logic [2:0] REG_HEIGHT = 3'd1;
   localparam logic [2:0] REG_C1     = 3'd2;
   localparam logic [2:0] REG_C2     = 3'd3;
   localparam logic [2:0] REG_C3     = 3'd4;
   localparam logic [2:0] REG_C4     = 3'd5;

   localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hff;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
   } fcg_req_type;

   typedef struct packed {
      logic [31:0] pixel_rgba;
      logic        out_of_range;
   } fcg_rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0] image_width;
      logic [DIM_W-1:0] image_height;
      logic [RGB_W-1:0] corner_one_rgb;
      logic [RGB_W-1:0] corner_two_rgb;
      logic [RGB_W-1:0] corner_three_rgb;
      logic [RGB_W-1:0] corner_four_rgb;
   } fcg_cfg_type;

   // state passed from one divider cell to the next
   typedef struct packed {
      logic                           valid;
      logic                           oor;
      logic [DEN_W-1:0]               den;
      logic [NUM_CH-1:0][NUM_W-1:0]   rem;
      logic [NUM_CH-1:0][CH_W-1:0]    quo;
   } fcg_div_type;

endpackage

FILE: hdl/four_corner_gradient_pixel.sv
// ----------------------------------------------------------------------------
// four_corner_gradient_pixel
// Bilinear four-corner gradient: one RGBA word per pixel coordinate.
// ----------------------------------------------------------------------------
// pipeline: 2 front stages (capture, vertical blends), 8 divider cells and
// 1 output register; throughput: one item per cycle, busy stays low.
// the divider chain settles one quotient bit per cell for all three channels.
// reset is synchronous; it clears the pipeline valid bits and sets width and
// height to 1 and the corner colours to 0. results cannot be stalled.
module four_corner_gradient_pixel (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  fcg_pkg::fcg_req_type       req_item,
   output logic                       rsp_valid,
   output fcg_pkg::fcg_rsp_type       rsp_item,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [fcg_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [fcg_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [fcg_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready
);
   import fcg_pkg::*;

   // datapath widths are sized for this clamp
   localparam int MAX_DIM = DEF_MAX_DIM;

   fcg_cfg_type cfg;

   fcg_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   assign busy = 1'b0;

   logic req_accept;
   assign req_accept = start & ~busy;

   // dimension clamp
   logic [DIM_W-1:0] w_eff, h_eff;
   assign w_eff = (32'(cfg.image_width) > MAX_DIM)  ? DIM_W'(MAX_DIM) : cfg.image_width;
   assign h_eff = (32'(cfg.image_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg.image_height;

   // stage 0: capture coordinate and range check
   logic               s0_valid_ff, s0_oor_ff;
   logic [COORD_W-1:0] s0_x_ff, s0_y_ff;
   logic [DIM_W-1:0]   s0_w_ff, s0_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= req_accept;
      end
      s0_x_ff   <= req_item.pixel_x;
      s0_y_ff   <= req_item.pixel_y;
      s0_w_ff   <= w_eff;
      s0_h_ff   <= h_eff;
      s0_oor_ff <= (DIM_W'(req_item.pixel_x) >= w_eff) ||
                   (DIM_W'(req_item.pixel_y) >= h_eff);
   end

   // stage 1: vertical blends and divisor
   logic [NUM_CH-1:0][BLEND_W-1:0] s1_a_in, s1_b_in;
   logic [NUM_CH-1:0][BLEND_W-1:0] s1_a_ff, s1_b_ff;
   logic                           s1_valid_ff, s1_oor_ff;
   logic [COORD_W-1:0]             s1_x_ff;
   logic [DIM_W-1:0]               s1_wx_ff;
   logic [DEN_W-1:0]               s1_den_ff;
   logic [DIM_W-1:0]               hy;

   assign hy = s0_h_ff - DIM_W'(s0_y_ff);

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         s1_a_in[c] = BLEND_W'(cfg.corner_one_rgb[c*CH_W +: CH_W] * s0_y_ff)
                    + BLEND_W'(cfg.corner_two_rgb[c*CH_W +: CH_W] * hy);
         s1_b_in[c] = BLEND_W'(cfg.corner_four_rgb[c*CH_W +: CH_W] * s0_y_ff)
                    + BLEND_W'(cfg.corner_three_rgb[c*CH_W +: CH_W] * hy);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid_ff;
      end
      s1_a_ff   <= s1_a_in;
      s1_b_ff   <= s1_b_in;
      s1_oor_ff <= s0_oor_ff;
      s1_x_ff   <= s0_x_ff;
      s1_wx_ff  <= s0_w_ff - DIM_W'(s0_x_ff);
      s1_den_ff <= DEN_W'(s0_w_ff * s0_h_ff);
   end

   // stage 2: horizontal blend numerators
   fcg_div_type chain [0:CH_W];

   for (genvar c = 0; c < NUM_CH; c++) begin : g_num
      assign chain[0].rem[c] = NUM_W'(s1_a_ff[c] * s1_x_ff) + NUM_W'(s1_b_ff[c] * s1_wx_ff);
   end

   assign chain[0].valid = s1_valid_ff;
   assign chain[0].oor   = s1_oor_ff;
   assign chain[0].den   = s1_den_ff;
   assign chain[0].quo   = '0;

   // divider chain, most significant quotient bit first
   for (genvar i = 0; i < CH_W; i++) begin : g_cell
      fcg_div_cell #(.SHIFT(CH_W - 1 - i)) u_cell (
         .clock, .reset, .d_in(chain[i]), .d_out(chain[i+1])
      );
   end

   // output register
   logic        rsp_valid_ff;
   fcg_rsp_type rsp_item_ff, rsp_item_in;

   always_comb begin
      rsp_item_in.out_of_range = chain[CH_W].oor;
      if (chain[CH_W].oor) begin
         rsp_item_in.pixel_rgba = '0;
      end else begin
         rsp_item_in.pixel_rgba = {chain[CH_W].quo[2], chain[CH_W].quo[1],
                                   chain[CH_W].quo[0], ALPHA_OPAQUE};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= chain[CH_W].valid;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef ASSERT_OFF
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(req_accept, 11))
      else $error("result without matching item");
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.out_of_range) |-> (rsp_item_ff.pixel_rgba == '0))
      else $error("out of range pixel not zero");
   a_alpha: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_item_ff.out_of_range) |->
      (rsp_item_ff.pixel_rgba[CH_W-1:0] == ALPHA_OPAQUE))
      else $error("alpha not opaque");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      chain[CH_W].valid |-> (chain[CH_W].rem[0] < NUM_W'(chain[CH_W].den) ||
                             chain[CH_W].oor))
      else $error("divider remainder not below divisor");
`endif

endmodule

FILE: hdl/fcg_csr.sv
// ----------------------------------------------------------------------------
// fcg_csr
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module fcg_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [fcg_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [fcg_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [fcg_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready,
   output fcg_pkg::fcg_cfg_type       cfg
);
   import fcg_pkg::*;

   fcg_cfg_type cfg_ff, cfg_in;
   logic [2:0]  idx;
   logic        wr_en;

   assign idx        = csr_paddr[CSR_AW-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_WIDTH:  cfg_in.image_width      = csr_pwdata[DIM_W-1:0];
            REG_HEIGHT: cfg_in.image_height     = csr_pwdata[DIM_W-1:0];
            REG_C1:     cfg_in.corner_one_rgb   = csr_pwdata[RGB_W-1:0];
            REG_C2:     cfg_in.corner_two_rgb   = csr_pwdata[RGB_W-1:0];
            REG_C3:     cfg_in.corner_three_rgb = csr_pwdata[RGB_W-1:0];
            REG_C4:     cfg_in.corner_four_rgb  = csr_pwdata[RGB_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{image_width: DIM_W'(1), image_height: DIM_W'(1), default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      case (idx)
         REG_WIDTH:  csr_prdata = CSR_DW'(cfg_ff.image_width);
         REG_HEIGHT: csr_prdata = CSR_DW'(cfg_ff.image_height);
         REG_C1:     csr_prdata = CSR_DW'(cfg_ff.corner_one_rgb);
         REG_C2:     csr_prdata = CSR_DW'(cfg_ff.corner_two_rgb);
         REG_C3:     csr_prdata = CSR_DW'(cfg_ff.corner_three_rgb);
         REG_C4:     csr_prdata = CSR_DW'(cfg_ff.corner_four_rgb);
         default:    csr_prdata = '0;
      endcase
   end

endmodule

FILE: hdl/fcg_div_cell.sv
// ----------------------------------------------------------------------------
// fcg_div_cell
// One cell of the divider chain: settles one quotient bit for every channel.
// ----------------------------------------------------------------------------
module fcg_div_cell #(
   parameter int SHIFT = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fcg_pkg::fcg_div_type d_in,
   output fcg_pkg::fcg_div_type d_out
);
   import fcg_pkg::*;

   fcg_div_type        cell_ff, cell_in;
   logic [NUM_W-1:0]   den_sh;

   assign den_sh = NUM_W'(d_in.den) << SHIFT;

   // compare and subtract per channel
   always_comb begin
      cell_in = d_in;
      for (int c = 0; c < NUM_CH; c++) begin
         if (d_in.rem[c] >= den_sh) begin
            cell_in.rem[c]        = d_in.rem[c] - den_sh;
            cell_in.quo[c][SHIFT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= cell_in.valid;
      end
      cell_ff.oor <= cell_in.oor;
      cell_ff.den <= cell_in.den;
      cell_ff.rem <= cell_in.rem;
      cell_ff.quo <= cell_in.quo;
   end

   assign d_out = cell_ff;

endmodule
